### rtl/core/roas_pkg.sv
// Shared types and codes for the obstacle-avoidance sequencer.
// Used by roas_cfg, roas_core and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package roas_pkg;

	localparam int TICK_COUNT_WIDTH_DEF = 16;

	localparam int DIST_W     = 10;
	localparam int FWD_W      = 16;
	localparam int ATTEMPT_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// run modes
	localparam logic [1:0] MODE_HALTED = 2'd0;
	localparam logic [1:0] MODE_MOVING = 2'd1;
	localparam logic [1:0] MODE_AVOID  = 2'd2;

	// avoidance phases
	localparam logic [1:0] PH_ROT_CW  = 2'd0;
	localparam logic [1:0] PH_FORWARD = 2'd1;
	localparam logic [1:0] PH_ROT_CCW = 2'd2;
	localparam logic [1:0] PH_CHECK   = 2'd3;

	// light codes
	localparam logic [1:0] LIGHT_HALTED = 2'd0;
	localparam logic [1:0] LIGHT_MOVING = 2'd1;
	localparam logic [1:0] LIGHT_AVOID  = 2'd2;

	localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = 4'd15;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FWD_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ATT_LIMIT = 2'd2;

	// register reset values
	localparam logic [DIST_W-1:0]    THRESHOLD_RST = 10'd20;
	localparam logic [FWD_W-1:0]     FWD_TICKS_RST = 16'd1000;
	localparam logic [ATTEMPT_W-1:0] ATT_LIMIT_RST = 4'd3;

	typedef struct packed {
		logic [DIST_W-1:0]    threshold;
		logic [FWD_W-1:0]     fwd_ticks;
		logic [ATTEMPT_W-1:0] attempt_limit;
	} cfg_t;

	typedef struct packed {
		logic              button;
		logic [DIST_W-1:0] distance;
		logic              rot_done;
	} item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] phase;
		logic [1:0] light;
		logic       yaw_rst;
		logic       yaw_int;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/roas_cfg.sv
// Configuration register file of the obstacle-avoidance sequencer.
// Depends on roas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module roas_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [roas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [roas_pkg::CFG_DATA_W-1:0] cfg_data,
	output roas_pkg::cfg_t                       cfg
);

	logic [roas_pkg::DIST_W-1:0]    threshold_q;
	logic [roas_pkg::FWD_W-1:0]     fwd_ticks_q;
	logic [roas_pkg::ATTEMPT_W-1:0] att_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= roas_pkg::THRESHOLD_RST;
			fwd_ticks_q <= roas_pkg::FWD_TICKS_RST;
			att_limit_q <= roas_pkg::ATT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				roas_pkg::CFG_THRESHOLD: threshold_q <= cfg_data[roas_pkg::DIST_W-1:0];
				roas_pkg::CFG_FWD_TICKS: fwd_ticks_q <= cfg_data[roas_pkg::FWD_W-1:0];
				roas_pkg::CFG_ATT_LIMIT: att_limit_q <= cfg_data[roas_pkg::ATTEMPT_W-1:0];
				default: ; // unmapped index, ignored
			endcase
		end
	end

	assign cfg.threshold     = threshold_q;
	assign cfg.fwd_ticks     = fwd_ticks_q;
	assign cfg.attempt_limit = att_limit_q;

endmodule

`default_nettype wire

### rtl/core/roas_core.sv
// Mode/phase state machine and tick counters of the sequencer.
// One tick per advance; depends on roas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module roas_core #(
	parameter int TICK_COUNT_WIDTH = roas_pkg::TICK_COUNT_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  roas_pkg::item_t item,
	input  roas_pkg::cfg_t  cfg,
	output roas_pkg::result_t res
);

	// compare width covers both the counter and the forward_ticks register
	localparam int CMP_W = (TICK_COUNT_WIDTH > roas_pkg::FWD_W) ?
		TICK_COUNT_WIDTH : roas_pkg::FWD_W;

	logic [1:0]                     mode_q, mode_n;
	logic [1:0]                     phase_q, phase_n;
	logic [TICK_COUNT_WIDTH-1:0]    step_q, step_n;
	logic [roas_pkg::ATTEMPT_W-1:0] attempt_q, attempt_n;
	logic [1:0]                     light;
	logic                           yaw_rst, yaw_int;
	logic                           blocked;
	logic                           fwd_more;

	assign blocked  = item.distance < cfg.threshold;
	assign fwd_more = (CMP_W'(step_q) < CMP_W'(cfg.fwd_ticks)) && (step_q != '1);

	always_comb begin
		mode_n    = mode_q;
		phase_n   = phase_q;
		step_n    = step_q;
		attempt_n = attempt_q;
		light     = roas_pkg::LIGHT_HALTED;
		yaw_rst   = 1'b0;
		yaw_int   = 1'b0;
		unique case (mode_q)
			roas_pkg::MODE_MOVING: begin
				light = roas_pkg::LIGHT_MOVING;
				if (item.button)
					mode_n = roas_pkg::MODE_HALTED;
				if (blocked)
					mode_n = roas_pkg::MODE_AVOID;
			end
			roas_pkg::MODE_AVOID: begin
				light = roas_pkg::LIGHT_AVOID;
				if (item.button) begin
					// abort
					mode_n    = roas_pkg::MODE_HALTED;
					phase_n   = roas_pkg::PH_ROT_CW;
					step_n    = '0;
					attempt_n = '0;
				end else begin
					case (phase_q) inside
						roas_pkg::PH_ROT_CW, roas_pkg::PH_ROT_CCW: begin
							// step counter doubles as the yaw-reset-done flag
							if (step_q == '0) begin
								yaw_rst = 1'b1;
								step_n  = TICK_COUNT_WIDTH'(1);
							end
							yaw_int = 1'b1;
							if (item.rot_done) begin
								step_n = '0;
								if (phase_q == roas_pkg::PH_ROT_CW) begin
									phase_n = roas_pkg::PH_FORWARD;
								end else begin
									if (attempt_q < roas_pkg::ATTEMPT_MAX)
										attempt_n = attempt_q + 1'b1;
									phase_n = roas_pkg::PH_CHECK;
								end
							end
						end
						roas_pkg::PH_FORWARD: begin
							if (fwd_more) begin
								step_n = step_q + 1'b1;
							end else begin
								step_n  = '0;
								phase_n = roas_pkg::PH_ROT_CCW;
							end
						end
						default: begin // check
							phase_n = roas_pkg::PH_ROT_CW;
							if (attempt_q >= cfg.attempt_limit) begin
								attempt_n = '0;
								mode_n    = blocked ? roas_pkg::MODE_HALTED : roas_pkg::MODE_MOVING;
							end else if (!blocked) begin
								attempt_n = '0;
								mode_n    = roas_pkg::MODE_MOVING;
							end
						end
					endcase
				end
			end
			default: begin // halted, or the unused code
				light  = roas_pkg::LIGHT_HALTED;
				mode_n = item.button ? roas_pkg::MODE_MOVING : roas_pkg::MODE_HALTED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= roas_pkg::MODE_HALTED;
			phase_q   <= roas_pkg::PH_ROT_CW;
			step_q    <= '0;
			attempt_q <= '0;
		end else if (advance) begin
			mode_q    <= mode_n;
			phase_q   <= phase_n;
			step_q    <= step_n;
			attempt_q <= attempt_n;
		end
	end

	assign res.mode    = mode_n;
	assign res.phase   = phase_n;
	assign res.light   = light;
	assign res.yaw_rst = yaw_rst;
	assign res.yaw_int = yaw_int;

`ifndef SYNTHESIS
	a_abort_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_q == roas_pkg::MODE_AVOID && item.button |=>
		mode_q == roas_pkg::MODE_HALTED && phase_q == roas_pkg::PH_ROT_CW &&
		step_q == '0 && attempt_q == '0)
		else $error("abort did not clear avoidance state");

	a_no_state_change_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(mode_q) && $stable(phase_q) && $stable(step_q) &&
		$stable(attempt_q))
		else $error("state moved without a tick");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3)
		else $error("unused mode code reached");

	a_yaw_rst_in_rotation: assert property (@(posedge clk) disable iff (!arst_n)
		res.yaw_rst |-> res.yaw_int && mode_q == roas_pkg::MODE_AVOID &&
		(phase_q == roas_pkg::PH_ROT_CW || phase_q == roas_pkg::PH_ROT_CCW))
		else $error("yaw reset outside a rotation phase");
`endif

endmodule

`default_nettype wire

### rtl/core/robot_obstacle_avoid_sequencer.sv
// Top level of the obstacle-avoidance sequencer: input register, state logic,
// result register. Depends on roas_pkg, roas_cfg and roas_core.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   in       | in_valid / in_stall    | button_pressed, obstacle_distance,
//            |                        | rotation_done
//   out      | out_valid / out_stall  | run_mode, avoid_phase, light_code,
//            |                        | yaw_reset_request, yaw_integrate_request
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One tick per clock sustained while out_stall is low; a tick passes the input register,
// then the state update lands in the result register.
// The mode/phase/counter registers are the only loop; they feed back through combinational logic.
// Reset clears state, the valid flags and the registers to their defaults.
// A stalled result beat holds the result register; the input register then
// fills and raises in_stall until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module robot_obstacle_avoid_sequencer #(
	parameter int TICK_COUNT_WIDTH = roas_pkg::TICK_COUNT_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            button_pressed,
	input  wire logic [roas_pkg::DIST_W-1:0]     obstacle_distance,
	input  wire logic                            rotation_done,

	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           run_mode,
	output logic [1:0]                           avoid_phase,
	output logic [1:0]                           light_code,
	output logic                                 yaw_reset_request,
	output logic                                 yaw_integrate_request,

	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [roas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [roas_pkg::CFG_DATA_W-1:0] cfg_data
);

	roas_pkg::cfg_t    cfg;
	roas_pkg::item_t   item_s1;
	roas_pkg::result_t res_c, res_s2;
	logic              valid_s1, valid_s2;
	logic              s2_free, advance, in_take;

	assign cfg_ready = 1'b1;

	roas_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (s2_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.button   <= button_pressed;
			item_s1.distance <= obstacle_distance;
			item_s1.rot_done <= rotation_done;
		end
		if (advance)
			res_s2 <= res_c;
	end

	roas_core #(
		.TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_c)
	);

	assign out_valid             = valid_s2;
	assign run_mode              = res_s2.mode;
	assign avoid_phase           = res_s2.phase;
	assign light_code            = res_s2.light;
	assign yaw_reset_request     = res_s2.yaw_rst;
	assign yaw_integrate_request = res_s2.yaw_int;

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for robot_obstacle_avoid_sequencer: directed and random ticks,
// random idling on both channels, and register writes between phases.
// Depends on roas_pkg and the top level only.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TCW = roas_pkg::TICK_COUNT_WIDTH_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic button_pressed = 1'b0;
	logic [roas_pkg::DIST_W-1:0] obstacle_distance = '0;
	logic rotation_done = 1'b0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] run_mode;
	logic [1:0] avoid_phase;
	logic [1:0] light_code;
	logic yaw_reset_request;
	logic yaw_integrate_request;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [roas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [roas_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// sequencer state mirror and register copies
	logic [1:0] seq_mode = roas_pkg::MODE_HALTED;
	logic [1:0] seq_phase = roas_pkg::PH_ROT_CW;
	logic [TCW-1:0] fwd_count = '0;
	logic [roas_pkg::ATTEMPT_W-1:0] attempts = '0;
	logic [roas_pkg::DIST_W-1:0] cfg_thr = roas_pkg::THRESHOLD_RST;
	logic [roas_pkg::FWD_W-1:0] cfg_fwd = roas_pkg::FWD_TICKS_RST;
	logic [roas_pkg::ATTEMPT_W-1:0] cfg_limit = roas_pkg::ATT_LIMIT_RST;

	roas_pkg::result_t predicted_outputs[$];
	roas_pkg::result_t want_q;
	int mismatch_count = 0;
	int cycle_count = 0;
	bit gaps_on = 1'b1;
	int stall_left = 0;

	robot_obstacle_avoid_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.button_pressed(button_pressed),
		.obstacle_distance(obstacle_distance),
		.rotation_done(rotation_done),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.run_mode(run_mode),
		.avoid_phase(avoid_phase),
		.light_code(light_code),
		.yaw_reset_request(yaw_reset_request),
		.yaw_integrate_request(yaw_integrate_request),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// output backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// One tick of the sequencer on the mirrored state.
	task automatic step_sequencer(input logic btn, input logic [roas_pkg::DIST_W-1:0] distance,
			input logic rot, output roas_pkg::result_t r);
		logic blocked;
		logic [1:0] light;
		logic yr;
		logic yi;
		blocked = distance < cfg_thr;
		light = roas_pkg::LIGHT_HALTED;
		yr = 1'b0;
		yi = 1'b0;
		case (seq_mode)
			roas_pkg::MODE_MOVING: begin
				light = roas_pkg::LIGHT_MOVING;
				if (btn)
					seq_mode = roas_pkg::MODE_HALTED;
				if (blocked)
					seq_mode = roas_pkg::MODE_AVOID;
			end
			roas_pkg::MODE_AVOID: begin
				light = roas_pkg::LIGHT_AVOID;
				if (btn) begin
					seq_mode = roas_pkg::MODE_HALTED;
					seq_phase = roas_pkg::PH_ROT_CW;
					fwd_count = '0;
					attempts = '0;
				end else begin
					case (seq_phase) inside
						roas_pkg::PH_ROT_CW, roas_pkg::PH_ROT_CCW: begin
							// count acts as a flag here: zero means yaw clear still owed
							if (fwd_count == 0) begin
								yr = 1'b1;
								fwd_count = TCW'(1);
							end
							yi = 1'b1;
							if (rot) begin
								fwd_count = '0;
								if (seq_phase == roas_pkg::PH_ROT_CW) begin
									seq_phase = roas_pkg::PH_FORWARD;
								end else begin
									if (attempts < roas_pkg::ATTEMPT_MAX)
										attempts = attempts + 1'b1;
									seq_phase = roas_pkg::PH_CHECK;
								end
							end
						end
						roas_pkg::PH_FORWARD: begin
							if (fwd_count < cfg_fwd && fwd_count != '1) begin
								fwd_count = fwd_count + 1'b1;
							end else begin
								fwd_count = '0;
								seq_phase = roas_pkg::PH_ROT_CCW;
							end
						end
						default: begin
							seq_phase = roas_pkg::PH_ROT_CW;
							if (attempts >= cfg_limit) begin
								attempts = '0;
								seq_mode = blocked ? roas_pkg::MODE_HALTED
									: roas_pkg::MODE_MOVING;
							end else if (!blocked) begin
								attempts = '0;
								seq_mode = roas_pkg::MODE_MOVING;
							end
						end
					endcase
				end
			end
			default: begin
				seq_mode = btn ? roas_pkg::MODE_MOVING : roas_pkg::MODE_HALTED;
			end
		endcase
		r.mode = seq_mode;
		r.phase = seq_phase;
		r.light = light;
		r.yaw_rst = yr;
		r.yaw_int = yi;
	endtask

	task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// outputs are stable at the falling edge; a beat seen here is taken at the next rise
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_outputs.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got mode %0d phase %0d",
					$time, run_mode, avoid_phase);
				mismatch_count++;
			end else begin
				want_q = predicted_outputs.pop_front();
				check_field("run_mode", want_q.mode, run_mode);
				check_field("avoid_phase", want_q.phase, avoid_phase);
				check_field("light_code", want_q.light, light_code);
				check_field("yaw_reset_request", 2'(want_q.yaw_rst), 2'(yaw_reset_request));
				check_field("yaw_integrate_request", 2'(want_q.yaw_int),
					2'(yaw_integrate_request));
			end
		end
	end

	task automatic drive_tick(input logic btn, input logic [roas_pkg::DIST_W-1:0] distance,
			input logic rot);
		roas_pkg::result_t r;
		int gap;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		button_pressed <= btn;
		obstacle_distance <= distance;
		rotation_done <= rot;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		step_sequencer(btn, distance, rot, r);
		predicted_outputs.push_back(r);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [roas_pkg::CFG_IDX_W-1:0] idx,
			input logic [roas_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			roas_pkg::CFG_THRESHOLD: cfg_thr = val[roas_pkg::DIST_W-1:0];
			roas_pkg::CFG_FWD_TICKS: cfg_fwd = val[roas_pkg::FWD_W-1:0];
			roas_pkg::CFG_ATT_LIMIT: cfg_limit = val[roas_pkg::ATTEMPT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [roas_pkg::DIST_W-1:0] thr,
			input logic [roas_pkg::FWD_W-1:0] fwd,
			input logic [roas_pkg::ATTEMPT_W-1:0] lim);
		settle();
		write_reg(roas_pkg::CFG_THRESHOLD, roas_pkg::CFG_DATA_W'(thr));
		write_reg(roas_pkg::CFG_FWD_TICKS, roas_pkg::CFG_DATA_W'(fwd));
		write_reg(roas_pkg::CFG_ATT_LIMIT, roas_pkg::CFG_DATA_W'(lim));
	endtask

	function automatic logic [roas_pkg::DIST_W-1:0] pick_dist(input logic want_block);
		if (want_block && cfg_thr != 0)
			return roas_pkg::DIST_W'($urandom_range(0, int'(cfg_thr) - 1));
		if (!want_block)
			return roas_pkg::DIST_W'($urandom_range(int'(cfg_thr), 1023));
		return roas_pkg::DIST_W'($urandom_range(0, 1023));
	endfunction

	// mostly plausible ticks for the current mode, some pure noise
	task automatic random_tick();
		logic btn;
		logic rot;
		logic [roas_pkg::DIST_W-1:0] distance;
		btn = $urandom_range(0, 1);
		rot = $urandom_range(0, 1);
		distance = roas_pkg::DIST_W'($urandom_range(0, 1023));
		if ($urandom_range(0, 9) != 0) begin
			case (seq_mode)
				roas_pkg::MODE_AVOID: begin
					btn = ($urandom_range(0, 39) == 0);
					rot = ($urandom_range(0, 2) == 0);
					distance = pick_dist($urandom_range(0, 1));
				end
				roas_pkg::MODE_MOVING: begin
					btn = ($urandom_range(0, 7) == 0);
					distance = pick_dist($urandom_range(0, 3) == 0);
				end
				default: btn = ($urandom_range(0, 2) == 0);
			endcase
		end
		drive_tick(btn, distance, rot);
	endtask

	task automatic to_halted();
		while (seq_mode != roas_pkg::MODE_HALTED)
			drive_tick(1'b1, 10'd1023, 1'b0);
	endtask

	task automatic test_reset_defaults();
		drive_tick(1'b0, 10'd1023, 1'b0);
		drive_tick(1'b1, 10'd500, 1'b0);
		drive_tick(1'b0, 10'd20, 1'b0);   // at threshold: not an obstacle
		drive_tick(1'b0, 10'd19, 1'b0);
		drive_tick(1'b0, 10'd19, 1'b0);
		drive_tick(1'b1, 10'd0, 1'b1);    // abort during turn
	endtask

	task automatic test_directed();
		configure(10'd20, 16'd2, 4'd1);
		drive_tick(1'b1, 10'd1023, 1'b0);
		drive_tick(1'b0, 10'd0, 1'b0);
		drive_tick(1'b0, 10'd0, 1'b0);
		drive_tick(1'b0, 10'd0, 1'b1);
		drive_tick(1'b0, 10'd512, 1'b1);
		drive_tick(1'b0, 10'd512, 1'b0);
		drive_tick(1'b0, 10'd512, 1'b0);
		drive_tick(1'b0, 10'd1023, 1'b1); // yaw clear and done on one beat
		drive_tick(1'b0, 10'd0, 1'b0);    // check at limit, still blocked
		drive_tick(1'b1, 10'd100, 1'b0);
		drive_tick(1'b1, 10'd3, 1'b0);    // obstacle wins over button
		drive_tick(1'b1, 10'd0, 1'b1);
		drive_tick(1'b1, 10'd1023, 1'b1);
		drive_tick(1'b1, 10'd1023, 1'b1);
		drive_tick(1'b1, 10'd1023, 1'b0);
		drive_tick(1'b0, 10'd7, 1'b0);
		drive_tick(1'b0, 10'd7, 1'b1);
		repeat (3) drive_tick(1'b0, 10'd7, 1'b0);
		drive_tick(1'b0, 10'd7, 1'b1);
		drive_tick(1'b0, 10'd1023, 1'b0); // check at limit, path clear
	endtask

	task automatic test_zero_settings();
		configure(10'd1023, 16'd0, 4'd0);
		to_halted();
		drive_tick(1'b1, 10'd1023, 1'b0);
		drive_tick(1'b0, 10'd1022, 1'b1);
		drive_tick(1'b0, 10'd0, 1'b1);
		drive_tick(1'b0, 10'd0, 1'b0);    // zero forward ticks
		drive_tick(1'b0, 10'd0, 1'b1);
		drive_tick(1'b0, 10'd1023, 1'b0); // limit zero: any check ends it
		repeat (60) random_tick();
		configure(10'd0, 16'd3, 4'd0);
		repeat (40) random_tick();
	endtask

	task automatic test_random();
		logic [roas_pkg::DIST_W-1:0] thr;
		logic [roas_pkg::FWD_W-1:0] fwd;
		logic [roas_pkg::ATTEMPT_W-1:0] lim;
		for (int ph = 0; ph < 5; ph++) begin
			thr = (ph == 0) ? 10'd1023 : roas_pkg::DIST_W'($urandom_range(1, 1022));
			fwd = (ph == 4) ? roas_pkg::FWD_W'($urandom_range(20, 60))
				: roas_pkg::FWD_W'($urandom_range(0, 6));
			lim = (ph == 0) ? 4'd15 : (ph == 1) ? 4'd0
				: roas_pkg::ATTEMPT_W'($urandom_range(1, 14));
			configure(thr, fwd, lim);
			gaps_on = (ph != 2);
			repeat (320) random_tick();
		end
	endtask

	// run without idling: a long forward leg, then attempts up to the top limit
	task automatic test_long_forward();
		gaps_on = 1'b0;
		configure(10'd1023, 16'd200, 4'd15);
		to_halted();
		drive_tick(1'b1, 10'd1023, 1'b0);
		drive_tick(1'b0, 10'd0, 1'b0);
		drive_tick(1'b0, 10'd0, 1'b1);
		while (seq_mode == roas_pkg::MODE_AVOID && seq_phase == roas_pkg::PH_FORWARD)
			drive_tick(1'b0, roas_pkg::DIST_W'($urandom_range(0, 1023)),
				$urandom_range(0, 1));
		drive_tick(1'b0, 10'd1023, 1'b1);
		drive_tick(1'b0, 10'd1023, 1'b0);
		configure(10'd1023, 16'd0, 4'd15);
		while (seq_mode != roas_pkg::MODE_HALTED)
			drive_tick(1'b0, 10'd0, 1'b1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_zero_settings();
		test_random();
		test_long_forward();
		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
